[hdl/sfp_pkg.sv]
// Shared types, constants and helpers for the serial frame parser.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package sfp_pkg;

  // Largest payload a frame may carry
  localparam int MAX_PAYLOAD = 20;

  // Payload store index and length counter widths
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  // Output field widths
  localparam int LEN_OUT_W = 5;
  localparam int TDATA_W   = 40;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd2;

  localparam logic [7:0] BOARD_ADDRESS_RESET = 8'd0;
  localparam logic [7:0] HEADER_FIRST_RESET  = 8'd170;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'd85;
  localparam logic [7:0] BROADCAST_ADDRESS   = 8'd0;

  // Write request into the payload store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // Descriptor of one checked frame
  typedef struct packed {
    logic [7:0]       address;
    logic [7:0]       kind;
    logic [CNT_W-1:0] length;
  } frame_desc_t;

  // Mask a store index to the 5-bit output field
  function automatic logic [LEN_OUT_W-1:0] pos_to_field(input logic [IDX_W-1:0] p);
    logic [IDX_W+LEN_OUT_W-1:0] w;
    w = {{LEN_OUT_W{1'b0}}, p};
    return w[LEN_OUT_W-1:0];
  endfunction

  // Mask a length count to the 5-bit output field
  function automatic logic [LEN_OUT_W-1:0] len_to_field(input logic [CNT_W-1:0] n);
    logic [CNT_W+LEN_OUT_W-1:0] w;
    w = {{LEN_OUT_W{1'b0}}, n};
    return w[LEN_OUT_W-1:0];
  endfunction

endpackage

[hdl/serial_frame_parser_top.sv]
// Top level of the serial frame parser with XOR checksum.
// Instantiates sfp_front, sfp_queue and sfp_back; uses sfp_pkg.
//
// Received bytes enter on the slave stream, one byte per cycle while the
// parser hunts headers and takes the address, type and length bytes.
// Payload and check bytes of a frame are held off (s_tready low) while the
// previous frame is still being delivered, since both share one payload
// store. A frame whose check byte matches is delivered as one result per
// payload byte (one result for an empty payload), with tlast on the final
// one; each result takes a registered store read in ST_READ and is then
// presented in ST_EMIT, held there while the sink keeps m_tready low. Frames
// with a foreign address, an oversized length or a bad check byte produce
// no output. Configuration writes are always taken (cfg_ready is high).
module serial_frame_parser_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] frame_address, [15:8] frame_kind, [20:16] frame_length,
  // [25:21] byte_position, [33:26] payload_value, [39:34] zero
  output logic [sfp_pkg::TDATA_W-1:0]    m_tdata,
  output logic                           m_tlast    // last_of_frame
);

  logic                 queue_full;
  logic                 back_busy;
  logic                 push_valid;
  sfp_pkg::frame_desc_t push_desc;
  sfp_pkg::store_wr_t   store_wr;
  logic                 pop_valid;
  logic                 pop_ready;
  sfp_pkg::frame_desc_t pop_desc;

  assign cfg_ready = 1'b1;

  // Parse incoming bytes
  sfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .rx_byte    (s_tdata),
    .queue_full (queue_full),
    .back_busy  (back_busy),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .store_wr   (store_wr)
  );

  // Hold one checked frame descriptor
  sfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  // Deliver results
  sfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .store_wr   (store_wr),
    .desc_valid (pop_valid),
    .desc_ready (pop_ready),
    .desc       (pop_desc),
    .busy       (back_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

[hdl/sfp_front.sv]
// Front end of the serial frame parser: configuration registers, header
// hunt, field capture, checksum and payload store writes. Uses sfp_pkg.
module sfp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     rx_byte,
  input  logic                           queue_full,
  input  logic                           back_busy,
  output logic                           push_valid,
  output sfp_pkg::frame_desc_t           push_desc,
  output sfp_pkg::store_wr_t             store_wr
);

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_ADDR,
    PH_KIND,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t                     phase;
  logic [7:0]                 board_address;
  logic [7:0]                 header_first;
  logic [7:0]                 header_second;
  logic [7:0]                 running_xor;
  logic [sfp_pkg::CNT_W-1:0]  bytes_received;
  logic [7:0]                 held_address;
  logic [7:0]                 held_kind;
  logic [sfp_pkg::CNT_W-1:0]  held_length;

  logic                       accept;
  logic                       store_phase;
  logic [sfp_pkg::CNT_W-1:0]  bytes_received_next;

  // Hold payload and check bytes while the previous frame still drains
  assign store_phase = (phase == PH_DATA) || (phase == PH_CHECK);
  assign s_tready    = !store_phase || !(queue_full || back_busy);
  assign accept      = s_tvalid && s_tready;

  assign bytes_received_next = bytes_received + 1'b1;

  // Payload store write
  assign store_wr.we   = accept && (phase == PH_DATA);
  assign store_wr.addr = bytes_received[sfp_pkg::IDX_W-1:0];
  assign store_wr.data = rx_byte;

  // Push a descriptor when the check byte matches
  assign push_valid        = accept && (phase == PH_CHECK) && (running_xor == rx_byte);
  assign push_desc.address = held_address;
  assign push_desc.kind    = held_kind;
  assign push_desc.length  = held_length;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_address <= sfp_pkg::BOARD_ADDRESS_RESET;
      header_first  <= sfp_pkg::HEADER_FIRST_RESET;
      header_second <= sfp_pkg::HEADER_SECOND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfp_pkg::REG_BOARD_ADDRESS: board_address <= cfg_data;
        sfp_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data;
        sfp_pkg::REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parse one byte per request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEAD1;
      running_xor    <= '0;
      bytes_received <= '0;
      held_address   <= '0;
      held_kind      <= '0;
      held_length    <= '0;
    end else if (accept) begin
      case (phase)
        PH_HEAD1: begin
          if (rx_byte == header_first) phase <= PH_HEAD2;
        end
        PH_HEAD2: begin
          if (rx_byte == header_second) phase <= PH_ADDR;
          else if (rx_byte == header_first) phase <= PH_HEAD2;
          else phase <= PH_HEAD1;
        end
        PH_ADDR: begin
          if (rx_byte == board_address || rx_byte == sfp_pkg::BROADCAST_ADDRESS) begin
            held_address <= rx_byte;
            running_xor  <= rx_byte;
            phase        <= PH_KIND;
          end else begin
            phase <= PH_HEAD1;
          end
        end
        PH_KIND: begin
          held_kind   <= rx_byte;
          running_xor <= running_xor ^ rx_byte;
          phase       <= PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte > 8'(sfp_pkg::MAX_PAYLOAD)) begin
            phase <= PH_HEAD1;
          end else begin
            held_length    <= rx_byte[sfp_pkg::CNT_W-1:0];
            running_xor    <= running_xor ^ rx_byte;
            bytes_received <= '0;
            phase          <= (rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
          end
        end
        PH_DATA: begin
          running_xor    <= running_xor ^ rx_byte;
          bytes_received <= bytes_received_next;
          if (bytes_received_next >= held_length) phase <= PH_CHECK;
        end
        PH_CHECK: begin
          phase <= PH_HEAD1;
        end
        default: begin
          phase <= PH_HEAD1;
        end
      endcase
    end
  end

endmodule

[hdl/sfp_queue.sv]
// One-entry descriptor queue between front and back of the frame parser.
// Uses sfp_pkg for the descriptor type.
module sfp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  sfp_pkg::frame_desc_t  push_desc,
  output logic                  full,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output sfp_pkg::frame_desc_t  pop_desc
);

  logic                 occupied;
  sfp_pkg::frame_desc_t entry;

  assign full      = occupied;
  assign pop_valid = occupied;
  assign pop_desc  = entry;

  // Fill on push, empty on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (push_valid && !occupied) begin
      occupied <= 1'b1;
    end else if (pop_ready && occupied) begin
      occupied <= 1'b0;
    end
  end

  // Capture the descriptor
  always_ff @(posedge clk) begin
    if (push_valid && !occupied) begin
      entry <= push_desc;
    end
  end

endmodule

[hdl/sfp_back.sv]
// Back end of the frame parser: payload store and result sequencer.
// Uses sfp_pkg for widths, store write type and descriptor type.
module sfp_back (
  input  logic                           clk,
  input  logic                           rst,
  input  sfp_pkg::store_wr_t             store_wr,
  input  logic                           desc_valid,
  output logic                           desc_ready,
  input  sfp_pkg::frame_desc_t           desc,
  output logic                           busy,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sfp_pkg::TDATA_W-1:0]    m_tdata,
  output logic                           m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t                     state;
  sfp_pkg::frame_desc_t       cur;
  logic [sfp_pkg::IDX_W-1:0]  pos;
  logic [7:0]                 rd_data;
  logic [7:0]                 mem [sfp_pkg::MAX_PAYLOAD];

  logic                       empty_frame;
  logic                       last;
  logic [sfp_pkg::CNT_W-1:0]  pos_plus;
  logic [7:0]                 value;

  // Payload store: one write port from the front, registered read
  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    rd_data <= mem[pos];
  end

  assign empty_frame = (cur.length == '0);
  assign pos_plus    = {{(sfp_pkg::CNT_W-sfp_pkg::IDX_W){1'b0}}, pos} + 1'b1;
  assign last        = empty_frame || (pos_plus == cur.length);
  assign value       = empty_frame ? 8'd0 : rd_data;

  assign busy       = (state != ST_IDLE);
  assign desc_ready = (state == ST_IDLE);
  assign m_tvalid   = (state == ST_EMIT);
  assign m_tlast    = last;
  assign m_tdata    = {6'd0, value, sfp_pkg::pos_to_field(pos),
                       sfp_pkg::len_to_field(cur.length), cur.kind, cur.address};

  // Step through the frame, one result per store read
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (desc_valid) begin
            cur   <= desc;
            pos   <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (m_tready) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/tb.sv]
// Self-checking testbench for serial_frame_parser_top: streams framed bytes in,
// predicts each delivered payload beat and compares it with m_tdata/m_tlast.
// Depends on hdl/sfp_pkg.sv and the serial_frame_parser_top RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index outside the defined set; writes to it must be ignored
  localparam logic [sfp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam int HOLD_CYCLES    = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int REPORT_LIMIT   = 10;

  // Parser phases, mirrored from the frame layout
  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_ADDR, TAKE_KIND, TAKE_LEN, TAKE_DATA, TAKE_CHECK
  } parse_phase_t;

  // One delivered payload beat
  typedef struct packed {
    logic [7:0] address;
    logic [7:0] kind;
    logic [4:0] length;
    logic [4:0] position;
    logic [7:0] value;
    logic       last;
  } frame_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [sfp_pkg::TDATA_W-1:0]   m_tdata;
  logic                          m_tlast;

  serial_frame_parser_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Predictor state and its copy of the registers
  parse_phase_t phase;
  logic [7:0]   own_addr, hdr_first, hdr_second;
  logic [7:0]   csum_acc, frame_addr, frame_kind, frame_len;
  logic [7:0]   payload_buf [sfp_pkg::MAX_PAYLOAD];
  int           data_count;

  frame_beat_t  pending_beats [$];
  frame_beat_t  got_beat, want_beat;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int beats_seen = 0;
  int frames_seen = 0;
  int reg_writes = 0;
  int mismatches = 0;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predict the beats caused by one accepted byte
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_beat_t beat;
    case (phase)
      HUNT_FIRST: begin
        if (b == hdr_first) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == hdr_second) phase = TAKE_ADDR;
        else if (b == hdr_first) phase = HUNT_SECOND;
        else phase = HUNT_FIRST;
      end
      TAKE_ADDR: begin
        if (b == own_addr || b == sfp_pkg::BROADCAST_ADDRESS) begin
          frame_addr = b;
          csum_acc = b;
          phase = TAKE_KIND;
        end else begin
          phase = HUNT_FIRST;
        end
      end
      TAKE_KIND: begin
        frame_kind = b;
        csum_acc ^= b;
        phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        if (b > sfp_pkg::MAX_PAYLOAD) begin
          phase = HUNT_FIRST;
        end else begin
          frame_len = b;
          csum_acc ^= b;
          data_count = 0;
          phase = (b != 8'd0) ? TAKE_DATA : TAKE_CHECK;
        end
      end
      TAKE_DATA: begin
        if (data_count < sfp_pkg::MAX_PAYLOAD) payload_buf[data_count] = b;
        csum_acc ^= b;
        data_count++;
        if (data_count >= frame_len) phase = TAKE_CHECK;
      end
      TAKE_CHECK: begin
        if (csum_acc == b) begin
          beat.address = frame_addr;
          beat.kind = frame_kind;
          beat.length = frame_len[4:0];
          if (frame_len == 8'd0) begin
            beat.position = '0;
            beat.value = '0;
            beat.last = 1'b1;
            pending_beats.push_back(beat);
          end else begin
            for (int i = 0; i < frame_len && i < sfp_pkg::MAX_PAYLOAD; i++) begin
              beat.position = i[4:0];
              beat.value = payload_buf[i];
              beat.last = (i + 1 == frame_len);
              pending_beats.push_back(beat);
            end
          end
        end
        phase = HUNT_FIRST;
      end
      default: phase = HUNT_FIRST;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check every accepted beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_beat = {m_tdata[7:0], m_tdata[15:8], m_tdata[20:16], m_tdata[25:21],
                  m_tdata[33:26], m_tlast};
      beats_seen++;
      if (m_tlast) frames_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat addr %h kind %h len %0d pos %0d val %h last %b",
                                  got_beat.address, got_beat.kind, got_beat.length,
                                  got_beat.position, got_beat.value, got_beat.last));
      end else begin
        want_beat = pending_beats.pop_front();
        if (got_beat !== want_beat || m_tdata[39:34] !== '0) begin
          report_mismatch($sformatf(
            "addr %h/%h kind %h/%h len %0d/%0d pos %0d/%0d val %h/%h last %b/%b pad %h (exp/act)",
            want_beat.address, got_beat.address, want_beat.kind, got_beat.kind,
            want_beat.length, got_beat.length, want_beat.position, got_beat.position,
            want_beat.value, got_beat.value, want_beat.last, got_beat.last, m_tdata[39:34]));
        end
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d cycles without a request", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one byte, with random idle cycles first
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Drop valid, wait for all predicted beats, then let the pipeline settle
  task automatic drain;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sfp_pkg::REG_BOARD_ADDRESS: own_addr = val;
      sfp_pkg::REG_HEADER_FIRST:  hdr_first = val;
      sfp_pkg::REG_HEADER_SECOND: hdr_second = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Send a whole frame with random payload; stop after an oversized length
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] kind,
                            input logic [7:0] len, input int lead_first, input bit bad_check);
    logic [7:0] sum;
    logic [7:0] pay;
    repeat (lead_first) send_byte(hdr_first);
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(addr);
    send_byte(kind);
    send_byte(len);
    if (len > sfp_pkg::MAX_PAYLOAD) return;
    sum = addr ^ kind ^ len;
    for (int n = 0; n < len; n++) begin
      pay = 8'($urandom_range(255));
      sum ^= pay;
      send_byte(pay);
    end
    if (bad_check) sum ^= 8'(1 << $urandom_range(7));
    send_byte(sum);
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames
  task automatic random_frames(input int n_bytes);
    int stop_at;
    int pick;
    int lead;
    logic [7:0] addr;
    logic [7:0] len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) addr = own_addr;
        else if (pick < 80) addr = sfp_pkg::BROADCAST_ADDRESS;
        else addr = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 65) len = 8'($urandom_range(4));
        else if (pick < 75) len = 8'(sfp_pkg::MAX_PAYLOAD);
        else if (pick < 92) len = 8'($urandom_range(sfp_pkg::MAX_PAYLOAD - 1, 5));
        else len = 8'($urandom_range(255, sfp_pkg::MAX_PAYLOAD + 1));
        lead = (hdr_first != hdr_second && $urandom_range(99) < 15) ?
               int'($urandom_range(2, 1)) : 0;
        send_frame(addr, 8'($urandom_range(255)), len, lead, $urandom_range(99) < 15);
      end
    end
  endtask

  // Reset-value registers: the special cases, no idling
  task automatic test_directed;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_frame(sfp_pkg::BROADCAST_ADDRESS, 8'hFF, 8'd0, 0, 1'b0);
    send_frame(own_addr, 8'h00, 8'd1, 1, 1'b0);
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(8'h7E);
    send_frame(sfp_pkg::BROADCAST_ADDRESS, 8'h3C, 8'(sfp_pkg::MAX_PAYLOAD + 1), 0, 1'b0);
    send_frame(sfp_pkg::BROADCAST_ADDRESS, 8'hC3, 8'd0, 0, 1'b1);
  endtask

  // Extreme register values, sender idling
  task automatic test_extreme_registers;
    write_reg(sfp_pkg::REG_BOARD_ADDRESS, 8'hFF);
    write_reg(sfp_pkg::REG_HEADER_FIRST, 8'h00);
    write_reg(sfp_pkg::REG_HEADER_SECOND, 8'hFF);
    tx_idle_pct = 55;
    rx_stall_pct = 0;
    random_frames(20);
  endtask

  // Both header registers equal, receiver stalling
  task automatic test_equal_headers;
    write_reg(sfp_pkg::REG_BOARD_ADDRESS, 8'h5A);
    write_reg(sfp_pkg::REG_HEADER_FIRST, 8'hA5);
    write_reg(sfp_pkg::REG_HEADER_SECOND, 8'hA5);
    tx_idle_pct = 0;
    rx_stall_pct = 55;
    random_frames(20);
  endtask

  // Long receiver hold-off while frames keep coming, then pause to drain
  task automatic test_backpressure;
    write_reg(sfp_pkg::REG_HEADER_FIRST, 8'hAA);
    write_reg(sfp_pkg::REG_HEADER_SECOND, 8'h55);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1'b1;
    send_frame(own_addr, 8'h11, 8'(sfp_pkg::MAX_PAYLOAD), 0, 1'b0);
    send_frame(sfp_pkg::BROADCAST_ADDRESS, 8'h22, 8'd3, 0, 1'b0);
    drain();
  endtask

  // Write to the unused index must change nothing; both sides idle a little
  task automatic test_unused_index;
    write_reg(REG_UNUSED, 8'($urandom_range(255)));
    write_reg(sfp_pkg::REG_BOARD_ADDRESS, 8'($urandom_range(254, 1)));
    tx_idle_pct = 11;
    rx_stall_pct = 11;
    random_frames(20);
  endtask

  initial begin
    phase = HUNT_FIRST;
    own_addr = sfp_pkg::BOARD_ADDRESS_RESET;
    hdr_first = sfp_pkg::HEADER_FIRST_RESET;
    hdr_second = sfp_pkg::HEADER_SECOND_RESET;
    csum_acc = '0;
    frame_addr = '0;
    frame_kind = '0;
    frame_len = '0;
    data_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_extreme_registers();
    test_equal_headers();
    test_backpressure();
    test_unused_index();
    drain();

    $display("Sent %0d bytes and %0d register writes; checked %0d beats in %0d frames",
             bytes_sent, reg_writes, beats_seen, frames_seen);
    $display("Phases: directed cases, extreme registers, equal headers, hold-off, unused index");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sfp_pkg.sv
hdl/sfp_front.sv
hdl/sfp_queue.sv
hdl/sfp_back.sv
hdl/serial_frame_parser_top.sv
dv/tb.sv
